// File: rtl/core/dtjdn_pkg.sv
// Package for the date to Julian day number converter.
// Holds the calendar constants, date keys and month lookup functions.
// Depends on nothing; imported by date_to_julian_day_number.
package dtjdn_pkg;

  // Field widths of the transaction payload
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 6;
  localparam int unsigned JD_W    = 23;
  localparam int unsigned WD_W    = 3;
  localparam int unsigned KEY_W   = YEAR_W + MONTH_W + DAY_W;

  // Date keys: {year, month, day} read as one signed number keeps date order
  localparam logic [KEY_W-1:0] KEY_FIRST  = {14'h3fff - 14'd4713, 4'd11, 6'd24}; // 24 Nov -4714
  localparam logic [KEY_W-1:0] KEY_LAST   = {14'd3766, 4'd11, 6'd23};
  localparam logic [KEY_W-1:0] KEY_GAP_LO = {14'd1582, 4'd10, 6'd5};
  localparam logic [KEY_W-1:0] KEY_GAP_HI = {14'd1582, 4'd10, 6'd14};
  localparam logic [KEY_W-1:0] KEY_GREG   = {14'd1582, 4'd10, 6'd15};

  // Offsets of the Meeus formula
  localparam logic [14:0] YEAR_OFFSET = 15'd4716;
  localparam logic [23:0] JD_OFFSET   = 24'd1524;
  localparam logic [10:0] DAYS_PER_4Y = 11'd1461;

  // Reciprocals for constant division (exact over the stated operand width)
  localparam logic [14:0] RECIP_100_14B = 15'd20972;   // x/100 = (x*R) >> 21, x < 2^14
  localparam logic [12:0] RECIP_100_12B = 13'd5243;    // x/100 = (x*R) >> 19, x < 2^12
  localparam logic [22:0] RECIP_7_22B   = 23'd4793491; // x/7   = (x*R) >> 25, x < 2^22

  // Bias of 1 + 58*7: forms JD+1 and makes it nonnegative without changing it mod 7
  localparam logic [23:0] WD_BIAS = 24'd407;

  // floor(30.6001*(mm+1)) with January and February as months 13 and 14
  function automatic logic [8:0] month_term(input logic [MONTH_W-1:0] m);
    logic [8:0] t;
    case (m)
      4'd1:    t = 9'd428;
      4'd2:    t = 9'd459;
      4'd3:    t = 9'd122;
      4'd4:    t = 9'd153;
      4'd5:    t = 9'd183;
      4'd6:    t = 9'd214;
      4'd7:    t = 9'd244;
      4'd8:    t = 9'd275;
      4'd9:    t = 9'd306;
      4'd10:   t = 9'd336;
      4'd11:   t = 9'd367;
      4'd12:   t = 9'd397;
      default: t = 9'd0;
    endcase
    return t;
  endfunction

  // Month length under the Gregorian leap rule
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (m) inside
      4'd2:                      len = leap ? 6'd29 : 6'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 6'd30;
      default:                   len = 6'd31;
    endcase
    return len;
  endfunction

endpackage

// File: rtl/core/date_to_julian_day_number.sv
// Top level of the date to Julian day number converter.
// Three-register pipeline: input, computed date, result with weekday.
// Depends on dtjdn_pkg for constants and month tables.

// Converts one calendar date (signed year, month, day) per transaction into a
// validity flag, the Julian day number and the weekday (0 = Sunday). A date is
// valid when the month is 1..12, the day fits the month under the Gregorian
// leap rule, the year is not zero, the date lies from 24 Nov -4714 through
// 23 Nov 3766, and it is not in the reform gap 5..14 Oct 1582. Invalid dates
// return all fields zero. The Julian day follows Meeus in exact integers, with
// the Gregorian term applied from 15 Oct 1582 on. Rate: one transaction per
// cycle in and out while the output is not held. The three register stages
// (input, day number, weekday) move under one stall chain, so a held result
// stalls the input only while all stages hold valid data. The depth is set
// by the day-number adder chain and the mod 7 reciprocal multiply, each
// given a stage of its own.
module date_to_julian_day_number
  import dtjdn_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic signed [YEAR_W-1:0]  year_i,
  input  logic        [MONTH_W-1:0] month_i,
  input  logic        [DAY_W-1:0]   day_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      date_valid_o,
  output logic signed [JD_W-1:0]    julian_day_o,
  output logic        [WD_W-1:0]    weekday_o
);

  // Stall chain: a stage advances when it is empty or the next one advances
  logic out_en, mid_en, in_en;

  logic               in_vld_q, in_vld_d;
  logic [YEAR_W-1:0]  year_q;
  logic [MONTH_W-1:0] month_q;
  logic [DAY_W-1:0]   day_q;

  logic               mid_vld_q, mid_vld_d;
  logic               mid_ok_q, mid_ok_d;
  logic [JD_W-1:0]    mid_jd_q, mid_jd_d;

  logic               out_vld_q, out_vld_d;
  logic               out_ok_q;
  logic [JD_W-1:0]    out_jd_q;
  logic [WD_W-1:0]    out_wd_q, out_wd_d;

  assign out_en     = !out_vld_q || out_ready_i;
  assign mid_en     = !mid_vld_q || out_en;
  assign in_en      = !in_vld_q || mid_en;
  assign in_ready_o = in_en;

  assign in_vld_d  = in_en  ? in_valid_i : in_vld_q;
  assign mid_vld_d = mid_en ? in_vld_q   : mid_vld_q;
  assign out_vld_d = out_en ? mid_vld_q  : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mid_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      mid_vld_q <= mid_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Capture the input transaction
  always_ff @(posedge clk_i) begin
    if (in_en) begin
      year_q  <= year_i;
      month_q <= month_i;
      day_q   <= day_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: validity checks and Julian day number
  // ---------------------------------------------------------------------
  logic [YEAR_W-1:0]  year_abs;
  logic [28:0]        hund_prod;
  logic [6:0]         year_hund;
  logic [YEAR_W-1:0]  year_rem;
  logic               leap;
  logic               month_ok, day_ok, year_ok, span_ok, in_gap, greg;
  logic [KEY_W-1:0]   key;
  logic               early;
  logic [14:0]        yy;
  logic [14:0]        yy_off;
  logic [24:0]        year_prod;
  logic [24:0]        cent_prod;
  logic [5:0]         cent;
  logic [23:0]        greg_term;
  logic [23:0]        jd_sum;

  always_comb begin
    // Leap rule needs divisibility by 100 and 400; sign does not matter
    year_abs  = year_q[YEAR_W-1] ? (~year_q + 14'd1) : year_q;
    hund_prod = 29'(year_abs) * 29'(RECIP_100_14B);
    year_hund = hund_prod[27:21];
    year_rem  = year_abs - 14'(14'(year_hund) * 14'd100);
    leap      = ((year_q[1:0] == 2'd0) && (year_rem != '0)) ||
                ((year_rem == '0) && (year_hund[1:0] == 2'd0));

    month_ok = (month_q >= 4'd1) && (month_q <= 4'd12);
    day_ok   = (day_q != '0) && (day_q <= month_len(month_q, leap));
    year_ok  = (year_q != '0);

    // Compare dates as one signed key
    key     = {year_q, month_q, day_q};
    span_ok = ($signed(key) >= $signed(KEY_FIRST)) && ($signed(key) <= $signed(KEY_LAST));
    in_gap  = ($signed(key) >= $signed(KEY_GAP_LO)) && ($signed(key) <= $signed(KEY_GAP_HI));
    greg    = ($signed(key) >= $signed(KEY_GREG));

    mid_ok_d = month_ok && day_ok && year_ok && span_ok && !in_gap;

    // Count January and February as months 13 and 14 of the previous year
    early  = (month_q < 4'd3);
    yy     = {year_q[YEAR_W-1], year_q} - {14'd0, early};
    yy_off = yy + YEAR_OFFSET;

    // floor(365.25 * (yy + 4716)); operand is positive for every valid date
    year_prod = 25'(yy_off[13:0]) * 25'(DAYS_PER_4Y);

    // Gregorian term B = 2 - A + A/4 with A = yy/100 (yy positive here)
    cent_prod = 25'(yy[11:0]) * 25'(RECIP_100_12B);
    cent      = cent_prod[24:19];
    greg_term = greg ? (24'd2 - {18'd0, cent} + {20'd0, cent[5:2]}) : 24'd0;

    jd_sum = {1'b0, year_prod[24:2]} + {15'd0, month_term(month_q)} +
             {18'd0, day_q} + greg_term - JD_OFFSET;

    // Zero the day number of a rejected date
    mid_jd_d = mid_ok_d ? jd_sum[JD_W-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (mid_en) begin
      mid_ok_q <= mid_ok_d;
      mid_jd_q <= mid_jd_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: weekday = (JD + 1) mod 7
  // ---------------------------------------------------------------------
  logic [23:0] wd_x;
  logic [21:0] wd_xs;
  logic [44:0] wd_prod;
  logic [19:0] wd_quot;
  logic [21:0] wd_rem;

  always_comb begin
    // Add the 1 of JD + 1 and a multiple of 7 so the dividend is nonnegative
    wd_x    = {mid_jd_q[JD_W-1], mid_jd_q} + WD_BIAS;
    wd_xs   = wd_x[21:0];
    wd_prod = 45'(wd_xs) * 45'(RECIP_7_22B);
    wd_quot = wd_prod[44:25];
    wd_rem  = wd_xs - 22'(22'(wd_quot) * 22'd7);
    out_wd_d = mid_ok_q ? wd_rem[WD_W-1:0] : '0;
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_ok_q <= mid_ok_q;
      out_jd_q <= mid_jd_q;
      out_wd_q <= out_wd_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign date_valid_o = out_ok_q;
  assign julian_day_o = $signed(out_jd_q);
  assign weekday_o    = out_wd_q;

endmodule
